[design/ria_pkg.sv]
// Shared constants, types and digit-to-ASCII mapping for the radix converter.
package ria_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS_DEF = 64;

  localparam int FIELD_BITS = 64;  // width of the value port
  localparam int RADIX_BITS = 6;
  localparam int DIGIT_BITS = 6;
  localparam int CHAR_BITS  = 8;
  localparam int STEP_BITS  = 8;   // quotient bits resolved per divider cycle

  localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_BITS-1:0] ASCII_LOWER = 8'h61;  // 'a'
  localparam logic [CHAR_BITS-1:0] ASCII_UPPER = 8'h41;  // 'A'
  localparam logic [DIGIT_BITS-1:0] DECIMAL_TEN = 6'd10;

  typedef struct packed {
    logic load;  // take a new dividend, clear the partial remainder
    logic run;   // advance the division by one step
  } ria_div_ctrl_t;

  typedef struct packed {
    logic                  done;      // this step completes one digit
    logic                  quo_zero;  // quotient after this step is zero
    logic [DIGIT_BITS-1:0] digit;     // remainder after this step
  } ria_div_stat_t;

  function automatic logic [CHAR_BITS-1:0] glyph(input logic [DIGIT_BITS-1:0] d,
                                                  input logic up);
    logic [CHAR_BITS-1:0] base;
    base = up ? ASCII_UPPER : ASCII_LOWER;
    if (d < DECIMAL_TEN) begin
      return ASCII_ZERO + CHAR_BITS'(d);
    end
    return base + CHAR_BITS'(d - DECIMAL_TEN);
  endfunction

endpackage

[design/radix_integer_to_ascii.sv]
// Flow: the request is loaded, the divider yields each digit in STEP_BITS-bit passes, then each
//   character goes through stack read, glyph and hand-off, and the hand-off waits out any output stall.
// Throughput: one request at a time; a long conversion such as a 64-bit value in radix 2 is bound
//   by the shared 8-bit-per-cycle divider and the registered-read digit stack.
// A zero value skips the divider; with print_zero it goes straight to output as a lone '0'.
// Reset (rst, synchronous, active high) idles the sequencer; the digit stack is not cleared.
module radix_integer_to_ascii #(
  parameter int VALUE_BITS = ria_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = ria_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [ria_pkg::FIELD_BITS-1:0] value,
  input  logic [ria_pkg::RADIX_BITS-1:0] radix,
  input  logic                           upper_case,
  input  logic                           print_zero,
  // character channel
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [ria_pkg::CHAR_BITS-1:0]  character,
  output logic                           last
);

  localparam int AW = $clog2(MAX_DIGITS);      // digit stack address
  localparam int CW = $clog2(MAX_DIGITS + 1);  // digit count, holds MAX_DIGITS

  // Sequencer: IDLE takes a request, DIV runs the divider and pushes one
  // remainder per digit, then RD/LOAD/OUT pop the stack top-down, one
  // character per pass; a printed zero goes from IDLE straight to OUT.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_LOAD = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state;

  logic [ria_pkg::RADIX_BITS-1:0] base;      // clamped radix
  logic [ria_pkg::RADIX_BITS-1:0] base_next;
  logic                           upper;
  logic [CW-1:0]                  count;     // digits pushed so far
  logic [AW-1:0]                  rd_idx;    // stack entry being emitted

  logic [VALUE_BITS-1:0]          value_m;   // only the low VALUE_BITS count
  logic                           accept;

  ria_pkg::ria_div_ctrl_t         div_ctrl;
  ria_pkg::ria_div_stat_t         div_stat;

  logic [ria_pkg::DIGIT_BITS-1:0] stack_rdata;

  assign value_m   = value[VALUE_BITS-1:0];
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign res_valid = (state == ST_OUT);

  // radix outside 2..36 saturates
  always_comb begin
    base_next = radix;
    if (radix < ria_pkg::RADIX_MIN) begin
      base_next = ria_pkg::RADIX_MIN;
    end else if (radix > ria_pkg::RADIX_MAX) begin
      base_next = ria_pkg::RADIX_MAX;
    end
  end

  assign div_ctrl.load = accept && (value_m != '0);
  assign div_ctrl.run  = (state == ST_DIV);

  ria_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (value_m),
    .radix    (base),
    .stat     (div_stat)
  );

  // Remainders are pushed least significant first, so popping from the top
  // yields the most significant digit first.
  ria_ram #(
    .WIDTH (ria_pkg::DIGIT_BITS),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (div_stat.done),
    .waddr (count[AW-1:0]),
    .wdata (div_stat.digit),
    .raddr (rd_idx),
    .rdata (stack_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            count <= '0;
            if (value_m != '0) begin
              state <= ST_DIV;
            end else if (print_zero) begin
              // zero prints as a lone '0'
              state <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            count <= count + CW'(1);
            // stop on a zero quotient or a full stack (high digits dropped)
            if (div_stat.quo_zero || (count == CW'(MAX_DIGITS - 1))) begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_stall) begin
            state <= last ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request fields and output payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      base  <= base_next;
      upper <= upper_case;
      if (value_m == '0) begin
        character <= ria_pkg::ASCII_ZERO;
        last      <= 1'b1;
      end
    end
    if ((state == ST_DIV) && div_stat.done) begin
      rd_idx <= count[AW-1:0];
    end
    if (state == ST_LOAD) begin
      character <= ria_pkg::glyph(stack_rdata, upper);
      last      <= (rd_idx == '0);
    end
    if ((state == ST_OUT) && !res_stall && !last) begin
      rd_idx <= rd_idx - AW'(1);
    end
  end

endmodule

[design/ria_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ria_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ria_div.sv]
// Iterative divider: dividend by a 6-bit radix, STEP_BITS quotient bits per cycle while run is set.
module ria_div #(
  parameter int VALUE_BITS = ria_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ria_pkg::ria_div_ctrl_t         ctrl,
  input  logic [VALUE_BITS-1:0]          dividend,
  input  logic [ria_pkg::RADIX_BITS-1:0] radix,
  output ria_pkg::ria_div_stat_t         stat
);

  localparam int SB     = ria_pkg::STEP_BITS;
  localparam int RB     = ria_pkg::RADIX_BITS;
  localparam int PASSES = (VALUE_BITS + SB - 1) / SB;
  localparam int PW     = PASSES * SB;
  localparam int PCW    = (PASSES > 1) ? $clog2(PASSES) : 1;

  logic [PW-1:0]  quo;
  logic [PW-1:0]  quo_next;
  logic [RB-1:0]  rem;
  logic [RB-1:0]  rem_next;
  logic [SB-1:0]  qbits;
  logic [SB-1:0]  chunk;
  logic [PCW-1:0] pass;

  assign chunk = quo[PW-1 -: SB];

  // restoring steps; remainder stays below the radix so it fits in RB bits
  always_comb begin
    logic [RB:0] trial;
    rem_next = rem;
    qbits    = '0;
    for (int i = SB - 1; i >= 0; i--) begin
      trial = {rem_next, chunk[i]};
      if (trial >= {1'b0, radix}) begin
        trial    = trial - {1'b0, radix};
        qbits[i] = 1'b1;
      end
      rem_next = trial[RB-1:0];
    end
  end

  generate
    if (PASSES > 1) begin : g_multi
      assign quo_next = {quo[PW-SB-1:0], qbits};
    end else begin : g_single
      assign quo_next = qbits;
    end
  endgenerate

  assign stat.done     = ctrl.run && (pass == PCW'(PASSES - 1));
  assign stat.quo_zero = (quo_next == '0);
  assign stat.digit    = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass <= '0;
      rem  <= '0;
    end else if (ctrl.load) begin
      pass <= '0;
      rem  <= '0;
    end else if (ctrl.run) begin
      if (stat.done) begin
        pass <= '0;
        rem  <= '0;
      end else begin
        pass <= pass + PCW'(1);
        rem  <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      quo <= PW'(dividend);
    end else if (ctrl.run) begin
      quo <= quo_next;
    end
  end

endmodule
